// ===== hdl/rpcf_pkg.sv =====
package rpcf_pkg;

	// Palette size and level codes
	localparam int PALETTE_ENTRIES = 16;
	localparam int INDEX_W         = 4;
	localparam int LEVEL_W         = 8;
	localparam int NUM_CHANNELS    = 3;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 8'd255;
	localparam logic [LEVEL_W-1:0] LEVEL_FIRST  = 8'd254;
	localparam logic [LEVEL_W-1:0] DIVIDE_RESET = 8'd200;

	// Input action codes
	localparam logic ACTION_TICK  = 1'b0;
	localparam logic ACTION_START = 1'b1;

	// Colour word: red [23:16], green [15:8], blue [7:0]
	typedef logic [NUM_CHANNELS*LEVEL_W-1:0] color_t;

	localparam color_t PALETTE_ROM [PALETTE_ENTRIES] = '{
		{8'd255, 8'd0,   8'd0},
		{8'd0,   8'd255, 8'd0},
		{8'd0,   8'd0,   8'd255},
		{8'd255, 8'd160, 8'd16},
		{8'd255, 8'd224, 8'd32},
		{8'd255, 8'd208, 8'd160},
		{8'd160, 8'd128, 8'd96},
		{8'd128, 8'd128, 8'd128},
		{8'd160, 8'd32,  8'd254},
		{8'd100, 8'd118, 8'd135},
		{8'd45,  8'd52,  8'd74},
		{8'd118, 8'd96,  8'd138},
		{8'd240, 8'd163, 8'd10},
		{8'd0,   8'd0,   8'd0},
		{8'd85,  8'd255, 8'd255},
		{8'd170, 8'd255, 8'd170}
	};

	// State of one PWM channel
	typedef struct packed {
		logic [LEVEL_W-1:0] duty;
		logic               invert;
		logic               done;
	} chan_t;

	// Per-item control shared by all channels
	typedef struct packed {
		logic start;
		logic step;
		logic first;
	} chan_ctrl_t;

endpackage

// ===== hdl/rpcf_if.sv =====
interface rpcf_in_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [rpcf_pkg::INDEX_W-1:0] from_color;
	logic [rpcf_pkg::INDEX_W-1:0] to_color;

	modport source (output valid, output action, output from_color, output to_color,
		input ready);
	modport sink (input valid, input action, input from_color, input to_color,
		output ready);
endinterface

interface rpcf_out_if;
	logic                         valid;
	logic                         ready;
	logic [rpcf_pkg::LEVEL_W-1:0] red_duty;
	logic [rpcf_pkg::LEVEL_W-1:0] green_duty;
	logic [rpcf_pkg::LEVEL_W-1:0] blue_duty;
	logic                         red_inverted;
	logic                         green_inverted;
	logic                         blue_inverted;
	logic                         fade_busy;

	modport source (output valid, output red_duty, output green_duty, output blue_duty,
		output red_inverted, output green_inverted, output blue_inverted,
		output fade_busy, input ready);
	modport sink (input valid, input red_duty, input green_duty, input blue_duty,
		input red_inverted, input green_inverted, input blue_inverted,
		input fade_busy, output ready);
endinterface

// ===== hdl/rgb_pwm_color_fader.sv =====
// Channel    Dir  Handshake      Payload
// in_item    in   valid/ready    action, from_color, to_color
// out_item   out  valid/ready    red/green/blue duty, red/green/blue inverted, fade_busy
// cfg        in   cfg_we         cfg_wdata = tick_divide
//
// Each item's state update and its result are formed in the cycle it is
// accepted, and the result sits in the output register the next cycle.
// One item per cycle is sustained; in_item.ready drops only while a result waits
// in the output register and out_item.ready is low.
// Reset clears all fade state and sets tick_divide to 200.
module rgb_pwm_color_fader (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rpcf_pkg::LEVEL_W-1:0] cfg_wdata,
	rpcf_in_if.sink                      in_item,
	rpcf_out_if.source                   out_item
);

	logic [rpcf_pkg::LEVEL_W-1:0] divide_q;
	logic [rpcf_pkg::LEVEL_W-1:0] count_q;
	logic [rpcf_pkg::INDEX_W-1:0] src_idx_q;
	logic [rpcf_pkg::INDEX_W-1:0] tgt_idx_q;
	logic                         first_q;
	logic                         busy_q;
	rpcf_pkg::chan_t              chan_q   [rpcf_pkg::NUM_CHANNELS];
	rpcf_pkg::chan_t              chan_nxt [rpcf_pkg::NUM_CHANNELS];

	logic                         out_valid_q;
	rpcf_pkg::chan_t              res_q    [rpcf_pkg::NUM_CHANNELS];
	logic                         res_busy_q;

	logic                         accept;
	logic                         do_start;
	logic                         do_tick;
	logic                         do_step;
	logic                         all_done;
	logic [rpcf_pkg::INDEX_W-1:0] src_sel;
	logic [rpcf_pkg::INDEX_W-1:0] tgt_sel;
	rpcf_pkg::color_t             src_color;
	rpcf_pkg::color_t             tgt_color;
	rpcf_pkg::chan_ctrl_t         ctrl;
	logic                         busy_nxt;
	logic                         first_nxt;
	logic [rpcf_pkg::LEVEL_W-1:0] count_nxt;

	// Accept while the output register is free or being drained
	assign in_item.ready = !out_valid_q || out_item.ready;
	assign accept        = in_item.valid && in_item.ready;
	assign do_start      = accept && in_item.action == rpcf_pkg::ACTION_START && !busy_q;
	assign do_tick       = accept && in_item.action == rpcf_pkg::ACTION_TICK && busy_q;
	assign do_step       = do_tick && count_q == divide_q;

	// Pick palette entries: new indices on start, stored ones otherwise
	assign src_sel   = do_start ? in_item.from_color : src_idx_q;
	assign tgt_sel   = do_start ? in_item.to_color : tgt_idx_q;
	assign src_color = rpcf_pkg::PALETTE_ROM[src_sel];
	assign tgt_color = rpcf_pkg::PALETTE_ROM[tgt_sel];

	assign ctrl = '{start: do_start, step: do_step, first: first_q};

	// Per-channel level update
	for (genvar c = 0; c < rpcf_pkg::NUM_CHANNELS; c++) begin : g_chan
		localparam int HI = (rpcf_pkg::NUM_CHANNELS - c) * rpcf_pkg::LEVEL_W - 1;
		rpcf_channel u_channel (
			.ctrl      (ctrl),
			.src_level (src_color[HI -: rpcf_pkg::LEVEL_W]),
			.tgt_level (tgt_color[HI -: rpcf_pkg::LEVEL_W]),
			.cur       (chan_q[c]),
			.nxt       (chan_nxt[c])
		);
	end

	assign all_done = chan_nxt[0].done && chan_nxt[1].done && chan_nxt[2].done;

	// Work out busy, first-step mark and prescale count
	always_comb begin
		busy_nxt  = busy_q;
		first_nxt = first_q;
		count_nxt = count_q;
		if (do_start) begin
			busy_nxt  = 1'b1;
			first_nxt = 1'b1;
		end else if (do_tick) begin
			count_nxt = (do_step ? '0 : count_q) + 8'd1;
			if (do_step) begin
				first_nxt = 1'b0;
			end
			if (all_done) begin
				busy_nxt  = 1'b0;
				first_nxt = 1'b1;
			end
		end
	end

	// Hold the divide register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divide_q <= rpcf_pkg::DIVIDE_RESET;
		end else if (cfg_we) begin
			divide_q <= cfg_wdata;
		end
	end

	// Advance the fade state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			src_idx_q <= '0;
			tgt_idx_q <= '0;
			first_q   <= 1'b1;
			busy_q    <= 1'b0;
			for (int c = 0; c < rpcf_pkg::NUM_CHANNELS; c++) begin
				chan_q[c] <= '0;
			end
		end else if (accept) begin
			count_q   <= count_nxt;
			src_idx_q <= src_sel;
			tgt_idx_q <= tgt_sel;
			first_q   <= first_nxt;
			busy_q    <= busy_nxt;
			for (int c = 0; c < rpcf_pkg::NUM_CHANNELS; c++) begin
				chan_q[c] <= {chan_nxt[c].duty, chan_nxt[c].invert,
					chan_nxt[c].done && !(do_tick && all_done)};
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_item.ready) begin
			out_valid_q <= accept;
		end
	end

	// Capture the result item
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < rpcf_pkg::NUM_CHANNELS; c++) begin
				res_q[c] <= chan_nxt[c];
			end
			res_busy_q <= busy_nxt;
		end
	end

	assign out_item.valid          = out_valid_q;
	assign out_item.red_duty       = res_q[0].duty;
	assign out_item.green_duty     = res_q[1].duty;
	assign out_item.blue_duty      = res_q[2].duty;
	assign out_item.red_inverted   = res_q[0].invert;
	assign out_item.green_inverted = res_q[1].invert;
	assign out_item.blue_inverted  = res_q[2].invert;
	assign out_item.fade_busy      = res_busy_q;

endmodule

// ===== hdl/rpcf_channel.sv =====
module rpcf_channel (
	input  rpcf_pkg::chan_ctrl_t         ctrl,
	input  logic [rpcf_pkg::LEVEL_W-1:0] src_level,
	input  logic [rpcf_pkg::LEVEL_W-1:0] tgt_level,
	input  rpcf_pkg::chan_t              cur,
	output rpcf_pkg::chan_t              nxt
);

	rpcf_pkg::chan_t pre;

	// Load the source level, or release a full level on the first step
	always_comb begin
		pre = cur;
		if (ctrl.start) begin
			pre.done = 1'b0;
			if (src_level == rpcf_pkg::LEVEL_FULL) begin
				pre.invert = 1'b1;
				pre.duty   = '0;
			end else begin
				pre.invert = 1'b0;
				pre.duty   = src_level;
			end
		end else if (ctrl.step && ctrl.first && src_level == rpcf_pkg::LEVEL_FULL) begin
			pre.invert = 1'b0;
			pre.duty   = rpcf_pkg::LEVEL_FIRST;
		end
	end

	// Step one level toward the target, or mark done on arrival
	always_comb begin
		nxt = pre;
		if (ctrl.step && !pre.done) begin
			if (pre.duty > tgt_level) begin
				nxt.duty = pre.duty - 8'd1;
			end else if (pre.duty < tgt_level) begin
				nxt.duty = pre.duty + 8'd1;
			end else begin
				nxt.done = 1'b1;
				if (tgt_level == rpcf_pkg::LEVEL_FULL) begin
					nxt.invert = 1'b1;
					nxt.duty   = '0;
				end
			end
		end
	end

endmodule

// ===== bench/rgb_pwm_color_fader_tb.sv =====
module rgb_pwm_color_fader_tb;

	// Levels of one result item
	typedef struct packed {
		logic [rpcf_pkg::LEVEL_W-1:0] red_duty;
		logic [rpcf_pkg::LEVEL_W-1:0] green_duty;
		logic [rpcf_pkg::LEVEL_W-1:0] blue_duty;
		logic                         red_inv;
		logic                         green_inv;
		logic                         blue_inv;
		logic                         busy;
	} shade_t;

	// Tracks the fade state and holds the levels still to be seen on the output
	class fade_tracker;
		logic [rpcf_pkg::LEVEL_W-1:0] divide;
		logic [rpcf_pkg::LEVEL_W-1:0] prescale;
		logic [rpcf_pkg::LEVEL_W-1:0] duty [rpcf_pkg::NUM_CHANNELS];
		logic                         invert [rpcf_pkg::NUM_CHANNELS];
		logic                         done [rpcf_pkg::NUM_CHANNELS];
		logic                         first_pending;
		logic                         busy;
		logic [rpcf_pkg::INDEX_W-1:0] src_idx;
		logic [rpcf_pkg::INDEX_W-1:0] dst_idx;
		shade_t                       expected_shades [$];
		int                           mismatches;
		int                           checked;

		function new();
			divide        = rpcf_pkg::DIVIDE_RESET;
			prescale      = '0;
			first_pending = 1'b1;
			busy          = 1'b0;
			src_idx       = '0;
			dst_idx       = '0;
			mismatches    = 0;
			checked       = 0;
			for (int ch = 0; ch < rpcf_pkg::NUM_CHANNELS; ch++) begin
				duty[ch]   = '0;
				invert[ch] = 1'b0;
				done[ch]   = 1'b0;
			end
		endfunction

		// Red is channel 0, blue channel 2
		static function logic [rpcf_pkg::LEVEL_W-1:0] palette_level(
				logic [rpcf_pkg::INDEX_W-1:0] idx, int ch);
			rpcf_pkg::color_t c;
			c = rpcf_pkg::PALETTE_ROM[idx];
			return c[(rpcf_pkg::NUM_CHANNELS-1-ch)*rpcf_pkg::LEVEL_W +: rpcf_pkg::LEVEL_W];
		endfunction

		// Largest per-channel distance between two palette colours
		static function int colour_span(logic [rpcf_pkg::INDEX_W-1:0] a,
				logic [rpcf_pkg::INDEX_W-1:0] b);
			int widest;
			int gap;
			widest = 0;
			for (int ch = 0; ch < rpcf_pkg::NUM_CHANNELS; ch++) begin
				gap = int'(palette_level(a, ch)) - int'(palette_level(b, ch));
				if (gap < 0)
					gap = -gap;
				if (gap > widest)
					widest = gap;
			end
			return widest;
		endfunction

		function int pending();
			return expected_shades.size();
		endfunction

		// Advance the fade for one accepted item and note the levels it leaves
		function void take_item(logic act, logic [rpcf_pkg::INDEX_W-1:0] f,
				logic [rpcf_pkg::INDEX_W-1:0] t);
			logic [rpcf_pkg::LEVEL_W-1:0] goal;
			logic [rpcf_pkg::LEVEL_W-1:0] lvl;
			shade_t                       s;
			if (act == rpcf_pkg::ACTION_START) begin
				if (!busy) begin
					src_idx = f;
					dst_idx = t;
					for (int ch = 0; ch < rpcf_pkg::NUM_CHANNELS; ch++) begin
						lvl = palette_level(src_idx, ch);
						// full level shows as inverted output at zero duty
						invert[ch] = (lvl == rpcf_pkg::LEVEL_FULL);
						duty[ch]   = (lvl == rpcf_pkg::LEVEL_FULL) ? '0 : lvl;
						done[ch]   = 1'b0;
					end
					first_pending = 1'b1;
					busy          = 1'b1;
				end
			end else if (busy) begin
				if (prescale == divide) begin
					// first step drops full channels back to plain output at 254
					if (first_pending) begin
						for (int ch = 0; ch < rpcf_pkg::NUM_CHANNELS; ch++) begin
							if (palette_level(src_idx, ch) == rpcf_pkg::LEVEL_FULL) begin
								invert[ch] = 1'b0;
								duty[ch]   = rpcf_pkg::LEVEL_FIRST;
							end
						end
						first_pending = 1'b0;
					end
					for (int ch = 0; ch < rpcf_pkg::NUM_CHANNELS; ch++) begin
						goal = palette_level(dst_idx, ch);
						if (!done[ch]) begin
							if (duty[ch] > goal)
								duty[ch] = duty[ch] - 1'b1;
							else if (duty[ch] < goal)
								duty[ch] = duty[ch] + 1'b1;
							else begin
								done[ch] = 1'b1;
								if (goal == rpcf_pkg::LEVEL_FULL) begin
									invert[ch] = 1'b1;
									duty[ch]   = '0;
								end
							end
						end
					end
					prescale = '0;
				end
				prescale = prescale + 1'b1;
				if (done[0] && done[1] && done[2]) begin
					busy          = 1'b0;
					first_pending = 1'b1;
					for (int ch = 0; ch < rpcf_pkg::NUM_CHANNELS; ch++)
						done[ch] = 1'b0;
				end
			end
			s.red_duty   = duty[0];
			s.green_duty = duty[1];
			s.blue_duty  = duty[2];
			s.red_inv    = invert[0];
			s.green_inv  = invert[1];
			s.blue_inv   = invert[2];
			s.busy       = busy;
			expected_shades.push_back(s);
		endfunction

		function void match_field(string name, logic [rpcf_pkg::LEVEL_W-1:0] want,
				logic [rpcf_pkg::LEVEL_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		// Compare one result item against the oldest expectation
		function void check_result(shade_t got);
			shade_t want;
			checked++;
			if (expected_shades.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, got %h",
					$time, got);
				mismatches++;
				return;
			end
			want = expected_shades.pop_front();
			match_field("red_duty", want.red_duty, got.red_duty);
			match_field("green_duty", want.green_duty, got.green_duty);
			match_field("blue_duty", want.blue_duty, got.blue_duty);
			match_field("red_inverted", 8'(want.red_inv), 8'(got.red_inv));
			match_field("green_inverted", 8'(want.green_inv), 8'(got.green_inv));
			match_field("blue_inverted", 8'(want.blue_inv), 8'(got.blue_inv));
			match_field("fade_busy", 8'(want.busy), 8'(got.busy));
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	logic [rpcf_pkg::LEVEL_W-1:0] cfg_wdata;

	rpcf_in_if  in_if ();
	rpcf_out_if out_if ();

	rgb_pwm_color_fader dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_if),
		.out_item  (out_if)
	);

	fade_tracker tracker;
	int          burst_left;
	int          fade_items;
	int          rx_cycle;
	int          hold_left;
	bit          hold_done;

	always #5 clk = ~clk;

	// Note accepted items and check accepted results
	always @(posedge clk) begin
		shade_t seen;
		if (arst_n) begin
			if (in_if.valid && in_if.ready)
				tracker.take_item(in_if.action, in_if.from_color, in_if.to_color);
			if (out_if.valid && out_if.ready) begin
				seen.red_duty   = out_if.red_duty;
				seen.green_duty = out_if.green_duty;
				seen.blue_duty  = out_if.blue_duty;
				seen.red_inv    = out_if.red_inverted;
				seen.green_inv  = out_if.green_inverted;
				seen.blue_inv   = out_if.blue_inverted;
				seen.busy       = out_if.fade_busy;
				tracker.check_result(seen);
			end
		end
	end

	// Receiver: rotate through stall patterns, with one long hold-off
	always @(posedge clk) begin
		if (!arst_n)
			out_if.ready <= 1'b0;
		else begin
			rx_cycle++;
			if (hold_left != 0) begin
				hold_left--;
				out_if.ready <= 1'b0;
			end else if (!hold_done && tracker.checked >= 250) begin
				hold_done = 1'b1;
				hold_left = 60;
				out_if.ready <= 1'b0;
			end else begin
				case ((rx_cycle / 48) % 3)
					0: begin
						out_if.ready <= 1'b1;
					end
					1: begin
						out_if.ready <= ($urandom_range(0, 99) < 65);
					end
					default: begin
						out_if.ready <= ((rx_cycle % 5) < 3);
					end
				endcase
			end
		end
	end

	// Offer one item, opening a new burst after a random gap when due
	task automatic send_item(input logic act, input logic [rpcf_pkg::INDEX_W-1:0] f,
			input logic [rpcf_pkg::INDEX_W-1:0] t);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
			if (gap != 0) begin
				in_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = int'($urandom_range(1, 20));
		end
		in_if.valid      <= 1'b1;
		in_if.action     <= act;
		in_if.from_color <= f;
		in_if.to_color   <= t;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		burst_left--;
	endtask

	// Drop valid and wait until every result is in
	task automatic drain();
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_divide(input logic [rpcf_pkg::LEVEL_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.divide = value;
	endtask

	// Pick a pair of colours close enough for a fade to finish quickly
	task automatic pick_close_pair(output logic [rpcf_pkg::INDEX_W-1:0] f,
			output logic [rpcf_pkg::INDEX_W-1:0] t, output int span);
		int tries;
		tries = 0;
		do begin
			f     = 4'($urandom_range(0, rpcf_pkg::PALETTE_ENTRIES-1));
			t     = 4'($urandom_range(0, rpcf_pkg::PALETTE_ENTRIES-1));
			span  = fade_tracker::colour_span(f, t);
			tries++;
		end while (span > 70 && tries < 50);
	endtask

	// Start one fade and feed it enough ticks, with stray starts mixed in
	task automatic run_fade(input int div_val);
		logic [rpcf_pkg::INDEX_W-1:0] f_idx;
		logic [rpcf_pkg::INDEX_W-1:0] t_idx;
		int                           span;
		int                           tick_total;
		pick_close_pair(f_idx, t_idx, span);
		send_item(rpcf_pkg::ACTION_START, f_idx, t_idx);
		fade_items++;
		tick_total = (span + 3) * (div_val + 1) + int'($urandom_range(0, 8));
		repeat (tick_total) begin
			if ($urandom_range(0, 24) == 0)
				send_item(rpcf_pkg::ACTION_START, 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)));
			else begin
				send_item(rpcf_pkg::ACTION_TICK, 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)));
				fade_items++;
			end
		end
	endtask

	initial begin
		int div_val;
		tracker          = new();
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = rpcf_pkg::DIVIDE_RESET;
		in_if.valid      = 1'b0;
		in_if.action     = rpcf_pkg::ACTION_TICK;
		in_if.from_color = '0;
		in_if.to_color   = '0;
		out_if.ready     = 1'b0;
		burst_left       = 0;
		fade_items       = 0;
		rx_cycle         = 0;
		hold_left        = 0;
		hold_done        = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Tick while idle leaves the count alone
		send_item(rpcf_pkg::ACTION_TICK, 4'd15, 4'd0);
		drain();
		write_divide(8'd1);

		// All-dark fade, with a start while busy
		send_item(rpcf_pkg::ACTION_START, 4'd13, 4'd13);
		send_item(rpcf_pkg::ACTION_START, 4'd5, 4'd6);
		send_item(rpcf_pkg::ACTION_TICK, 4'd0, 4'd15);
		send_item(rpcf_pkg::ACTION_TICK, 4'd0, 4'd0);
		send_item(rpcf_pkg::ACTION_TICK, 4'd0, 4'd0);

		// Full red to full red: first step releases to 254 and steps to 255, then back to inverted
		send_item(rpcf_pkg::ACTION_START, 4'd0, 4'd0);
		send_item(rpcf_pkg::ACTION_TICK, 4'd0, 4'd0);
		send_item(rpcf_pkg::ACTION_TICK, 4'd0, 4'd0);

		// Full green source and target, then full green and blue
		send_item(rpcf_pkg::ACTION_START, 4'd15, 4'd15);
		send_item(rpcf_pkg::ACTION_TICK, 4'd0, 4'd0);
		send_item(rpcf_pkg::ACTION_TICK, 4'd0, 4'd0);
		send_item(rpcf_pkg::ACTION_START, 4'd14, 4'd14);
		send_item(rpcf_pkg::ACTION_TICK, 4'd0, 4'd0);
		send_item(rpcf_pkg::ACTION_TICK, 4'd0, 4'd0);
		send_item(rpcf_pkg::ACTION_TICK, 4'd0, 4'd0);

		// Full red source fading down, green fading up
		send_item(rpcf_pkg::ACTION_START, 4'd3, 4'd12);
		repeat (4) send_item(rpcf_pkg::ACTION_TICK, 4'd0, 4'd0);
		drain();

		// Random phases, each under its own divide
		while (fade_items < 120) begin
			div_val = ($urandom_range(0, 9) < 6) ? 1 : int'($urandom_range(2, 6));
			write_divide(div_val[rpcf_pkg::LEVEL_W-1:0]);
			repeat ($urandom_range(2, 4))
				run_fade(div_val);
			drain();
		end

		// Divide of 255: one step every 255 ticks
		write_divide(8'd255);
		run_fade(0);
		repeat (270) send_item(rpcf_pkg::ACTION_TICK, 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15)));
		drain();

		if (tracker.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Hard stop well past the slowest correct run
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
